[sv/rfd_pkg.sv]
// shared types and constants for the run-length frame delta decoder
// used by every module of the decoder; no dependencies of its own
`default_nettype none

package rfd_pkg;

  // row * width + column never exceeds 127 * 128 + 127, so it fits 14 bits
  localparam int unsigned IdxRawW    = 14;
  // reciprocal used for the frame store index modulo
  localparam int unsigned RecipShift = 28;
  localparam int unsigned RecipW     = 23;
  localparam int unsigned QuotW      = 8;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned ApbAddrW   = 5;
  localparam int unsigned ApbDataW   = 32;

  typedef enum logic [1:0] {
    OP_FRAME_START = 2'd0,
    OP_LOAD_RUN    = 2'd1,
    OP_TICK        = 2'd2
  } opcode_e;

  typedef enum logic [2:0] {
    REG_FRAME_WIDTH  = 3'd0,
    REG_FRAME_HEIGHT = 3'd1,
    REG_ORIGIN_X     = 3'd2,
    REG_ORIGIN_Y     = 3'd3,
    REG_CELL_SCALE   = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] run_count;
    logic [7:0] run_value;
  } in_item_t;

  typedef struct packed {
    logic [6:0]  cell_x;
    logic [6:0]  cell_y;
    logic [12:0] screen_x;
    logic [12:0] screen_y;
    logic        is_white;
    logic        changed;
    logic        run_end;
    logic        frame_done;
  } out_item_t;

  // clamped configuration as seen by the datapath
  typedef struct packed {
    logic [7:0]  width;
    logic [7:0]  height;
    logic [11:0] origin_x;
    logic [11:0] origin_y;
    logic [4:0]  scale;
  } cfg_t;

  // one cell to be drawn, handed from the sequencer to the store pipeline
  typedef struct packed {
    logic [6:0] cx;
    logic [6:0] cy;
    logic       white;
    logic       run_end;
    logic       done;
  } cell_job_t;

  function automatic logic [7:0] clamp_dim(input logic [7:0] v);
    logic [7:0] r;
    r = v;
    if (v == 8'd0) begin
      r = 8'd1;
    end else if (v > 8'd128) begin
      r = 8'd128;
    end
    return r;
  endfunction

  function automatic logic [4:0] clamp_scale(input logic [4:0] s);
    logic [4:0] r;
    r = s;
    if (s == 5'd0) begin
      r = 5'd1;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[sv/rfd_front.sv]
// raster sequencer: accepts items, tracks position and pending run, emits cell jobs
// depends on rfd_pkg
`default_nettype none

module rfd_front import rfd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      hold_i,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  input  logic      q_full_i,
  output logic      push_o,
  output cell_job_t job_o
);

  logic [6:0] col_q, col_d;
  logic [7:0] row_q, row_d;
  logic [7:0] left_q, left_d;
  logic       white_q, white_d;

  logic       accept;
  logic [7:0] next_col;
  logic [7:0] row_inc;
  logic [7:0] left_dec;
  logic       wrap;
  logic       fin;
  logic       cell_pending;

  assign in_ready_o   = !q_full_i && !hold_i;
  assign accept       = in_valid_i && in_ready_o;
  assign next_col     = {1'b0, col_q} + 8'd1;
  assign row_inc      = row_q + 8'd1;
  assign left_dec     = left_q - 8'd1;
  assign wrap         = next_col >= cfg_i.width;
  assign fin          = wrap && (row_inc >= cfg_i.height);
  assign cell_pending = (left_q != 8'd0) && (row_q < cfg_i.height);

  always_comb begin
    job_o.cx      = col_q;
    job_o.cy      = row_q[6:0];
    job_o.white   = white_q;
    job_o.done    = fin;
    // a frame that completes mid-run closes the run as well
    job_o.run_end = fin || (left_dec == 8'd0);
  end

  always_comb begin
    col_d   = col_q;
    row_d   = row_q;
    left_d  = left_q;
    white_d = white_q;
    push_o  = 1'b0;
    if (accept) begin
      case (in_item_i.opcode)
        OP_FRAME_START: begin
          col_d  = 7'd0;
          row_d  = 8'd0;
          left_d = 8'd0;
        end
        OP_LOAD_RUN: begin
          if (row_q >= cfg_i.height) begin
            left_d = 8'd0;
          end else begin
            left_d  = in_item_i.run_count;
            white_d = |in_item_i.run_value;
          end
        end
        OP_TICK: begin
          if (cell_pending) begin
            push_o = 1'b1;
            left_d = fin ? 8'd0 : left_dec;
            if (wrap) begin
              col_d = 7'd0;
              row_d = row_inc;
            end else begin
              col_d = next_col[6:0];
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= 7'd0;
      row_q   <= 8'd0;
      left_q  <= 8'd0;
      white_q <= 1'b0;
    end else begin
      col_q   <= col_d;
      row_q   <= row_d;
      left_q  <= left_d;
      white_q <= white_d;
    end
  end

endmodule

`default_nettype wire

[sv/rfd_fifo.sv]
// short job queue between the sequencer and the frame store pipeline
// depends on rfd_pkg
`default_nettype none

module rfd_fifo import rfd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  cell_job_t push_data_i,
  output logic      full_o,
  output logic      valid_o,
  input  logic      ready_i,
  output cell_job_t data_o
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QueueDepth - 1);

  cell_job_t       entries_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [PtrW:0]   cnt_q, cnt_d;
  logic            pop;

  assign full_o  = cnt_q == (PtrW + 1)'(QueueDepth);
  assign valid_o = cnt_q != '0;
  assign data_o  = entries_q[rd_ptr_q];
  assign pop     = valid_o && ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

`default_nettype wire

[sv/rfd_back.sv]
// frame store pipeline: index and screen math, store read-modify-write, result register
// depends on rfd_pkg; holds the previous-frame memory and its clearing pass
`default_nettype none

module rfd_back import rfd_pkg::*; #(
  parameter int unsigned FrameCells = 16384
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      job_valid_i,
  output logic      job_ready_o,
  input  cell_job_t job_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o,
  output logic      clearing_o
);

  localparam int unsigned IdxW   = $clog2(FrameCells);
  localparam int unsigned ProdW  = IdxRawW + RecipW;
  localparam logic [RecipW-1:0]  RecipM   = RecipW'((32'd1 << RecipShift) / FrameCells + 1);
  localparam logic [IdxRawW-1:0] CellsLow = IdxRawW'(FrameCells % (1 << IdxRawW));
  localparam logic [IdxW-1:0]    LastIdx  = IdxW'(FrameCells - 1);

  // stage 1: raw index and screen coordinates
  logic               s1_v_q;
  cell_job_t          s1_job_q;
  logic [IdxRawW-1:0] s1_raw_q;
  logic [12:0]        s1_sx_q, s1_sy_q;
  // stage 2: quotient by the store depth
  logic               s2_v_q;
  cell_job_t          s2_job_q;
  logic [IdxRawW-1:0] s2_raw_q;
  logic [QuotW-1:0]   s2_quot_q;
  logic [12:0]        s2_sx_q, s2_sy_q;
  // stage 3: store index
  logic               s3_v_q;
  cell_job_t          s3_job_q;
  logic [IdxW-1:0]    s3_idx_q;
  logic [12:0]        s3_sx_q, s3_sy_q;
  // stage 4: result register with the old stored bit
  logic               s4_v_q;
  cell_job_t          s4_job_q;
  logic [12:0]        s4_sx_q, s4_sy_q;
  logic               rd_q;

  logic               mem_q [FrameCells];
  logic               clr_q;
  logic [IdxW-1:0]    clr_cnt_q;

  logic               s1_rdy, s2_rdy, s3_rdy, s4_rdy;
  logic               adv1, adv2, adv3, adv4;
  logic [14:0]        row_off;
  logic [IdxRawW-1:0] raw_idx;
  logic [11:0]        cx_scaled, cy_scaled;
  logic [12:0]        sx_d, sy_d;
  logic [ProdW-1:0]   recip_prod;
  logic [QuotW-1:0]   quot;
  logic [IdxRawW-1:0] quot_cells;
  logic [IdxRawW-1:0] rem;

  assign s4_rdy = !s4_v_q || out_ready_i;
  assign s3_rdy = !s3_v_q || s4_rdy;
  assign s2_rdy = !s2_v_q || s3_rdy;
  assign s1_rdy = !s1_v_q || s2_rdy;
  assign adv1   = job_valid_i && s1_rdy;
  assign adv2   = s1_v_q && s2_rdy;
  assign adv3   = s2_v_q && s3_rdy;
  assign adv4   = s3_v_q && s4_rdy;

  assign job_ready_o = s1_rdy;
  assign clearing_o  = clr_q;

  assign row_off   = 15'(job_i.cy) * 15'(cfg_i.width);
  assign raw_idx   = IdxRawW'(row_off + 15'(job_i.cx));
  assign cx_scaled = 12'(job_i.cx) * 12'(cfg_i.scale);
  assign cy_scaled = 12'(job_i.cy) * 12'(cfg_i.scale);
  assign sx_d      = 13'(cfg_i.origin_x) + 13'(cx_scaled);
  assign sy_d      = 13'(cfg_i.origin_y) + 13'(cy_scaled);

  // exact quotient for any raw index below 2^14 by the scaled reciprocal
  assign recip_prod = ProdW'(s1_raw_q) * ProdW'(RecipM);
  assign quot       = recip_prod[RecipShift +: QuotW];

  assign quot_cells = IdxRawW'(IdxRawW'(s2_quot_q) * CellsLow);
  assign rem        = s2_raw_q - quot_cells;

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      s1_job_q <= job_i;
      s1_raw_q <= raw_idx;
      s1_sx_q  <= sx_d;
      s1_sy_q  <= sy_d;
    end
    if (adv2) begin
      s2_job_q  <= s1_job_q;
      s2_raw_q  <= s1_raw_q;
      s2_quot_q <= quot;
      s2_sx_q   <= s1_sx_q;
      s2_sy_q   <= s1_sy_q;
    end
    if (adv3) begin
      s3_job_q <= s2_job_q;
      s3_idx_q <= IdxW'(rem);
      s3_sx_q  <= s2_sx_q;
      s3_sy_q  <= s2_sy_q;
    end
    if (adv4) begin
      s4_job_q <= s3_job_q;
      s4_sx_q  <= s3_sx_q;
      s4_sy_q  <= s3_sy_q;
    end
  end

  // read-modify-write: the old bit is captured and the new colour stored on the same edge
  always_ff @(posedge clk_i) begin
    if (clr_q) begin
      mem_q[clr_cnt_q] <= 1'b0;
    end else if (adv4) begin
      mem_q[s3_idx_q] <= s3_job_q.white;
    end
    if (adv4) begin
      rd_q <= mem_q[s3_idx_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q    <= 1'b0;
      s2_v_q    <= 1'b0;
      s3_v_q    <= 1'b0;
      s4_v_q    <= 1'b0;
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
    end else begin
      if (s1_rdy) begin
        s1_v_q <= job_valid_i;
      end
      if (s2_rdy) begin
        s2_v_q <= s1_v_q;
      end
      if (s3_rdy) begin
        s3_v_q <= s2_v_q;
      end
      if (s4_rdy) begin
        s4_v_q <= s3_v_q;
      end
      if (clr_q) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
        if (clr_cnt_q == LastIdx) begin
          clr_q <= 1'b0;
        end
      end
    end
  end

  assign out_valid_o = s4_v_q;

  always_comb begin
    out_item_o.cell_x     = s4_job_q.cx;
    out_item_o.cell_y     = s4_job_q.cy;
    out_item_o.screen_x   = s4_sx_q;
    out_item_o.screen_y   = s4_sy_q;
    out_item_o.is_white   = s4_job_q.white;
    out_item_o.changed    = rd_q ^ s4_job_q.white;
    out_item_o.run_end    = s4_job_q.run_end;
    out_item_o.frame_done = s4_job_q.done;
  end

endmodule

`default_nettype wire

[sv/rle_frame_delta_decoder_core.sv]
// run-length frame delta decoder: items in on in_valid_i/in_ready_o, at most one cell
// result per tick on out_valid_o/out_ready_i, configuration over an APB-style port.
// An item is one beat: frame start, load run, or tick. Frame start and load run
// only update the raster sequencer and give no result; a tick with a pending run
// cell gives one result carrying cell and screen position, colour and a changed
// flag against the stored previous frame, which then takes the new colour.
// Throughput is one item per cycle while in_ready_o is high; a result passes
// through the job queue, the index/screen multiply, the reciprocal modulo stages
// and the store read-modify-write into the output register. The frame store has
// one port, touched once per cell, which sets the one-cell-per-cycle figure.
// After reset the store is swept to black, one entry per cycle through the whole
// store; in_ready_o stays low for that time while register writes are taken.
// When the receiver stalls, results back up through the four pipeline stages and
// the two-entry job queue, and in_ready_o falls only once the queue is full.
// Registers: 0 frame_width, 1 frame_height, 2 origin_x, 3 origin_y, 4 cell_scale
// at byte addresses 4*i; write only while the block is idle.
`default_nettype none

module rle_frame_delta_decoder_core import rfd_pkg::*; #(
  parameter int unsigned FRAME_CELLS = 16384
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_item_t            in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_item_t           out_item_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready
);

  logic [7:0]  width_q;
  logic [7:0]  height_q;
  logic [11:0] origin_x_q;
  logic [11:0] origin_y_q;
  logic [4:0]  scale_q;

  cfg_t        cfg;
  logic        reg_wr;
  logic        clearing;
  logic        q_full;
  logic        push;
  cell_job_t   push_job;
  logic        job_valid;
  logic        job_ready;
  cell_job_t   job;

  assign pready = 1'b1;
  assign reg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q    <= 8'd120;
      height_q   <= 8'd90;
      origin_x_q <= 12'd0;
      origin_y_q <= 12'd0;
      scale_q    <= 5'd1;
    end else if (reg_wr) begin
      case (paddr[4:2])
        REG_FRAME_WIDTH:  width_q    <= pwdata[7:0];
        REG_FRAME_HEIGHT: height_q   <= pwdata[7:0];
        REG_ORIGIN_X:     origin_x_q <= pwdata[11:0];
        REG_ORIGIN_Y:     origin_y_q <= pwdata[11:0];
        REG_CELL_SCALE:   scale_q    <= pwdata[4:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_FRAME_WIDTH:  prdata = ApbDataW'(width_q);
      REG_FRAME_HEIGHT: prdata = ApbDataW'(height_q);
      REG_ORIGIN_X:     prdata = ApbDataW'(origin_x_q);
      REG_ORIGIN_Y:     prdata = ApbDataW'(origin_y_q);
      REG_CELL_SCALE:   prdata = ApbDataW'(scale_q);
      default:          prdata = '0;
    endcase
  end

  always_comb begin
    cfg.width    = clamp_dim(width_q);
    cfg.height   = clamp_dim(height_q);
    cfg.origin_x = origin_x_q;
    cfg.origin_y = origin_y_q;
    cfg.scale    = clamp_scale(scale_q);
  end

  rfd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .hold_i     (clearing),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .job_o      (push_job)
  );

  rfd_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .full_o      (q_full),
    .valid_o     (job_valid),
    .ready_i     (job_ready),
    .data_o      (job)
  );

  rfd_back #(
    .FrameCells (FRAME_CELLS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .job_valid_i (job_valid),
    .job_ready_o (job_ready),
    .job_i       (job),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o),
    .clearing_o  (clearing)
  );

`ifndef SYNTHESIS
  // the store sweep runs with an empty pipeline, so nothing can come out
  a_no_result_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> !out_valid_o && !in_ready_o)
    else $error("result or input beat during store clearing");

  // a completing cell always closes its run
  a_done_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.frame_done |-> out_item_o.run_end)
    else $error("frame_done without run_end");

  // cells are only emitted on rows inside the frame
  a_row_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ({1'b0, out_item_o.cell_y} < cfg.height))
    else $error("cell emitted beyond the last row");

  // the queue is never pushed while full
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_full)
    else $error("job queue overflow");
`endif

endmodule

`default_nettype wire

[tb/rfd_cell_predictor.sv]
// predicts the cell stream of the run-length frame delta decoder from the
// accepted item and register-write beats, and compares every output beat with it
// depends on rfd_pkg only
module rfd_cell_predictor import rfd_pkg::*; #(
  parameter int unsigned FRAME_CELLS = 16384
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  in_item_t            in_item_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  out_item_t           out_item_i,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  input  logic                pready,
  output int unsigned         cells_due_o,
  output int unsigned         mismatches_o
);

  localparam int unsigned MaxPrinted = 200;

  // last colour drawn at each store entry
  bit          shown_frame [FRAME_CELLS];
  logic [6:0]  col_q;
  logic [7:0]  row_q;
  logic [7:0]  cells_left_q;
  logic        run_white_q;

  logic [7:0]  width_reg;
  logic [7:0]  height_reg;
  logic [11:0] org_x_reg;
  logic [11:0] org_y_reg;
  logic [4:0]  scale_reg;

  out_item_t   cells_due_q [$];
  int unsigned err_cnt;

  function automatic int unsigned fit_dim(input logic [7:0] v);
    if (v == 8'd0) begin
      return 1;
    end
    if (v > 8'd128) begin
      return 128;
    end
    return v;
  endfunction

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    err_cnt++;
    if (err_cnt <= MaxPrinted) begin
      $display("%0t: %s mismatch, got %0d, want %0d", $time, what, got, want);
    end
  endtask

  task automatic store_register(input logic [ApbAddrW-1:0] addr, input logic [31:0] val);
    case (reg_idx_e'(addr[ApbAddrW-1:2]))
      REG_FRAME_WIDTH:  width_reg  = val[7:0];
      REG_FRAME_HEIGHT: height_reg = val[7:0];
      REG_ORIGIN_X:     org_x_reg  = val[11:0];
      REG_ORIGIN_Y:     org_y_reg  = val[11:0];
      REG_CELL_SCALE:   scale_reg  = val[4:0];
      default: ;
    endcase
  endtask

  task automatic decode_item(input in_item_t it);
    int unsigned w;
    int unsigned h;
    int unsigned sc;
    int unsigned cx;
    int unsigned cy;
    int unsigned idx;
    out_item_t   pix;
    w  = fit_dim(width_reg);
    h  = fit_dim(height_reg);
    sc = (scale_reg == 5'd0) ? 1 : scale_reg;
    case (it.opcode)
      OP_FRAME_START: begin
        col_q        = '0;
        row_q        = '0;
        cells_left_q = '0;
      end
      OP_LOAD_RUN: begin
        // runs past the last row are dropped
        if (row_q >= h) begin
          cells_left_q = '0;
        end else begin
          cells_left_q = it.run_count;
          run_white_q  = (it.run_value != 8'd0);
        end
      end
      OP_TICK: begin
        if (cells_left_q != 8'd0 && row_q < h) begin
          cx  = col_q;
          cy  = row_q;
          idx = (cy * w + cx) % FRAME_CELLS;
          pix.cell_x     = 7'(cx);
          pix.cell_y     = 7'(cy);
          pix.screen_x   = 13'(org_x_reg + cx * sc);
          pix.screen_y   = 13'(org_y_reg + cy * sc);
          pix.is_white   = run_white_q;
          pix.changed    = (shown_frame[idx] != run_white_q);
          pix.frame_done = 1'b0;
          shown_frame[idx] = run_white_q;
          cells_left_q = cells_left_q - 8'd1;
          // a column past a shrunken width still emits, then wraps
          if (cx + 1 >= w) begin
            col_q = '0;
            row_q = row_q + 8'd1;
            if (row_q >= h) begin
              pix.frame_done = 1'b1;
              cells_left_q   = '0;
            end
          end else begin
            col_q = 7'(cx + 1);
          end
          pix.run_end = (cells_left_q == 8'd0);
          cells_due_q.push_back(pix);
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_cell(input out_item_t got);
    out_item_t want;
    if (cells_due_q.size() == 0) begin
      report_mismatch("unexpected cell", got, 0);
      return;
    end
    want = cells_due_q.pop_front();
    if (got.cell_x != want.cell_x) report_mismatch("cell_x", got.cell_x, want.cell_x);
    if (got.cell_y != want.cell_y) report_mismatch("cell_y", got.cell_y, want.cell_y);
    if (got.screen_x != want.screen_x) begin
      report_mismatch("screen_x", got.screen_x, want.screen_x);
    end
    if (got.screen_y != want.screen_y) begin
      report_mismatch("screen_y", got.screen_y, want.screen_y);
    end
    if (got.is_white != want.is_white) begin
      report_mismatch("is_white", got.is_white, want.is_white);
    end
    if (got.changed != want.changed) report_mismatch("changed", got.changed, want.changed);
    if (got.run_end != want.run_end) report_mismatch("run_end", got.run_end, want.run_end);
    if (got.frame_done != want.frame_done) begin
      report_mismatch("frame_done", got.frame_done, want.frame_done);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (shown_frame[i]) shown_frame[i] = 1'b0;
      col_q        = '0;
      row_q        = '0;
      cells_left_q = '0;
      run_white_q  = 1'b0;
      width_reg    = 8'd120;
      height_reg   = 8'd90;
      org_x_reg    = '0;
      org_y_reg    = '0;
      scale_reg    = 5'd1;
      cells_due_q.delete();
      err_cnt      = 0;
      cells_due_o  <= 0;
      mismatches_o <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        store_register(paddr, pwdata);
      end
      // a result never leaves in the cycle its tick beat is taken
      if (out_valid_i && out_ready_i) begin
        check_cell(out_item_i);
      end
      if (in_valid_i && in_ready_i) begin
        decode_item(in_item_i);
      end
      cells_due_o  <= cells_due_q.size();
      mismatches_o <= err_cnt;
    end
  end

endmodule

[tb/rle_frame_delta_decoder_core_tb.sv]
// top of the decoder bench: clock, reset, register writes, item and ready
// stimulus, watchdog and verdict; needs rfd_pkg, the core and rfd_cell_predictor
module rle_frame_delta_decoder_core_tb;
  import rfd_pkg::*;

  localparam int unsigned FRAME_CELLS    = 16384;
  localparam int unsigned CLK_PERIOD     = 10;
  localparam int unsigned RESET_CYCLES   = 5;
  localparam int unsigned HOLD_CYCLES    = 200;
  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned DRAIN_CYCLES   = 20;
  // covers the store sweep after reset several times over
  localparam int unsigned WATCHDOG_LIMIT = 4 * FRAME_CELLS;
  localparam int unsigned LONG_RUN_TICKS = 60;
  localparam logic [1:0]  OP_UNUSED      = 2'd3;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                in_valid;
  logic                in_ready;
  in_item_t            in_item;
  logic                out_valid;
  logic                out_ready;
  out_item_t           out_item;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [ApbDataW-1:0] pwdata;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  int unsigned cells_due;
  int unsigned mismatches;
  int unsigned idle_cycles  = 0;
  int unsigned inputs_sent  = 0;
  int unsigned holds_asked  = 0;
  int unsigned holds_done   = 0;
  int unsigned rx_stall_pct = 0;
  int unsigned tx_idle_pct  = 0;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  rle_frame_delta_decoder_core #(
    .FRAME_CELLS(FRAME_CELLS)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_item_o (out_item),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  rfd_cell_predictor #(
    .FRAME_CELLS(FRAME_CELLS)
  ) u_predictor (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_item_i   (in_item),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_item_i  (out_item),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .pready      (pready),
    .cells_due_o (cells_due),
    .mismatches_o(mismatches)
  );

  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver: random stalls, plus a long hold-off whenever one is asked for
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (holds_asked != holds_done) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        holds_done++;
      end
      out_ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  function automatic logic [7:0] pick_colour();
    return ($urandom_range(1) == 0) ? 8'd0 : 8'($urandom_range(255, 1));
  endfunction

  // setup then access; the bus is released by the caller after the last write
  task automatic write_reg(input reg_idx_e idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
  endtask

  task automatic set_frame(input logic [7:0] w, input logic [7:0] h,
                           input logic [11:0] ox, input logic [11:0] oy,
                           input logic [4:0] sc);
    write_reg(REG_FRAME_WIDTH, 32'(w));
    write_reg(REG_FRAME_HEIGHT, 32'(h));
    write_reg(REG_ORIGIN_X, 32'(ox));
    write_reg(REG_ORIGIN_Y, 32'(oy));
    write_reg(REG_CELL_SCALE, 32'(sc));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // valid stays up from one beat to the next unless a gap is drawn
  task automatic push_item(input logic [1:0] op, input logic [7:0] cnt,
                           input logic [7:0] val);
    in_item_t    it;
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < tx_idle_pct) gap++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    it.opcode    = op;
    it.run_count = cnt;
    it.run_value = val;
    in_item  <= it;
    in_valid <= 1'b1;
    do @(posedge clk_i); while (!in_ready);
    if (op != OP_UNUSED) begin
      inputs_sent++;
    end
  endtask

  task automatic push_ticks(input int unsigned n);
    repeat (n) push_item(OP_TICK, 8'($urandom_range(255)), 8'($urandom_range(255)));
  endtask

  // wait for the last cell, then let trailing no-result items drain
  task automatic settle;
    in_valid <= 1'b0;
    do @(posedge clk_i); while (cells_due != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // mostly a load run followed by its ticks, sometimes cut short or overrun
  task automatic play_segment(input int unsigned span);
    int unsigned pick;
    int unsigned runlen;
    int unsigned ticks;
    pick = $urandom_range(99);
    if (pick < 6) begin
      push_item(OP_FRAME_START, 8'($urandom_range(255)), 8'($urandom_range(255)));
    end else if (pick < 14) begin
      push_item(2'($urandom_range(3)), 8'($urandom_range(255)), 8'($urandom_range(255)));
    end else begin
      if ($urandom_range(3) == 0) begin
        runlen = $urandom_range(255);
      end else begin
        runlen = $urandom_range((span > 127) ? 255 : 2 * span + 1, 1);
      end
      push_item(OP_LOAD_RUN, 8'(runlen), pick_colour());
      if ($urandom_range(9) == 0) begin
        ticks = $urandom_range(runlen);
      end else begin
        ticks = runlen + (($urandom_range(4) == 0) ? $urandom_range(3, 1) : 0);
      end
      if (ticks > LONG_RUN_TICKS) begin
        ticks = LONG_RUN_TICKS;
      end
      push_ticks(ticks);
    end
  endtask

  task automatic run_phase(input logic [7:0] w, input logic [7:0] h,
                           input logic [11:0] ox, input logic [11:0] oy,
                           input logic [4:0] sc, input int unsigned tx_pct,
                           input int unsigned rx_pct, input int unsigned n_items,
                           input bit squeeze);
    int unsigned span;
    int unsigned stop_at;
    settle();
    set_frame(w, h, ox, oy, sc);
    tx_idle_pct = tx_pct;
    rx_stall_pct <= rx_pct;
    if (squeeze) begin
      holds_asked <= holds_asked + 1;
    end
    span    = (w == 8'd0) ? 1 : ((w > 8'd128) ? 128 : w);
    stop_at = inputs_sent + n_items;
    while (inputs_sent < stop_at) play_segment(span);
  endtask

  initial begin
    rst_ni   <= 1'b0;
    in_valid <= 1'b0;
    in_item  <= '0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // register writes go in while the store is still being swept
    set_frame(8'd4, 8'd3, 12'd10, 12'd20, 5'd0);
    push_item(OP_FRAME_START, 8'd0, 8'd0);
    push_item(OP_TICK, 8'hFF, 8'hFF);
    push_item(OP_UNUSED, 8'hFF, 8'hFF);
    push_item(OP_LOAD_RUN, 8'd0, 8'hFF);
    push_ticks(1);
    push_item(OP_LOAD_RUN, 8'd5, 8'h80);
    push_ticks(3);
    // replaces the open run and overruns the end of the frame
    push_item(OP_LOAD_RUN, 8'hFF, 8'h01);
    push_ticks(10);
    push_item(OP_LOAD_RUN, 8'd3, 8'h00);
    push_item(OP_FRAME_START, 8'd0, 8'd0);
    // black over white, every cell reports a change
    push_item(OP_LOAD_RUN, 8'd2, 8'h00);
    push_ticks(3);

    run_phase(8'd5, 8'd4, 12'd0, 12'd0, 5'd1, 0, 0, 100, 1'b1);
    run_phase(8'd0, 8'd255, 12'd4095, 12'd4095, 5'd31, 63, 0, 100, 1'b0);
    run_phase(8'd255, 8'd0, 12'd17, 12'd3000, 5'd16, 0, 63, 100, 1'b0);
    run_phase(8'd3, 8'd2, 12'd100, 12'd200, 5'd0, 38, 38, 100, 1'b0);
    run_phase(8'd128, 8'd128, 12'd0, 12'd0, 5'd1, 0, 0, 60, 1'b0);
    // narrower frame with the raster left wherever the wide one stopped
    run_phase(8'd6, 8'd5, 12'($urandom_range(4095)), 12'($urandom_range(4095)),
              5'($urandom_range(31)), 38, 38, 150, 1'b0);

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && cells_due == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
